// File: design/sbus_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// S.BUS frame receiver assertion macros
// Shared assertion shorthands for the frame receiver checker.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_RECEIVER_MACROS_SVH
`define SBUS_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clock and quiet during reset.
`define SBFR_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, sampled on clock and quiet during reset.
`define SBFR_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (conseq)) else $error(msg);

`endif

// File: design/sbfr_pkg.sv
// ----------------------------------------------------------------------------
// S.BUS frame receiver package
// Constants and shared types for the frame receiver and its cells.
// ----------------------------------------------------------------------------
package sbfr_pkg;

   localparam int FRAME_BYTES    = 25;
   localparam int GAP_COUNT_BITS = 8;
   localparam int CHANNELS       = 16;
   localparam int CHAN_BITS      = 11;
   localparam int DATA_BYTES     = CHANNELS * CHAN_BITS / 8;
   localparam int SEEN_BITS      = $clog2(FRAME_BYTES + 1);
   localparam int INDEX_BITS     = $clog2(CHANNELS);

   localparam logic [7:0] START_BYTE      = 8'h0f;
   localparam logic [7:0] END_BYTE        = 8'h00;
   localparam logic [7:0] GAP_LIMIT_RESET = 8'd2;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Control for one cell of the channel chain.
   typedef struct packed {
      logic load;
      logic shift;
   } chan_ctl_type;

endpackage

// File: design/sbfr_byte_cell.sv
// ----------------------------------------------------------------------------
// S.BUS byte cell
// One byte of the receive window; takes its neighbor's byte on each shift.
// ----------------------------------------------------------------------------
module sbfr_byte_cell (
   input  logic       clock,
   input  logic       shift,
   input  logic [7:0] d_in,
   output logic [7:0] q
);

   logic [7:0] byte_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         byte_ff <= d_in;
      end
   end

   assign q = byte_ff;

endmodule

// File: design/sbfr_chan_cell.sv
// ----------------------------------------------------------------------------
// S.BUS channel cell
// One 11-bit channel slot; loads from the frame or takes its neighbor's value.
// ----------------------------------------------------------------------------
module sbfr_chan_cell (
   input  logic                               clock,
   input  sbfr_pkg::chan_ctl_type             ctl,
   input  logic [sbfr_pkg::CHAN_BITS-1:0]     load_val,
   input  logic [sbfr_pkg::CHAN_BITS-1:0]     shift_in,
   output logic [sbfr_pkg::CHAN_BITS-1:0]     q
);

   logic [sbfr_pkg::CHAN_BITS-1:0] chan_ff;

   // Load and shift never occur together: loading only happens when the
   // chain is empty.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         chan_ff <= load_val;
      end else if (ctl.shift) begin
         chan_ff <= shift_in;
      end
   end

   assign q = chan_ff;

endmodule

// File: design/sbus_frame_receiver.sv
// ----------------------------------------------------------------------------
// S.BUS frame receiver
// Slides received bytes through a chain of byte cells and unpacks each
// valid frame into sixteen 11-bit channel beats.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                              Direction   Beat content
//   req       req_valid req_stall req_func ...   in          one byte or one tick
//   rsp       rsp_valid rsp_stall rsp_channel_*  out         one decoded channel
//   csr       csr_wr_en csr_wr_data              in          gap limit write
//
// The req channel takes one beat per cycle while req_stall is low; a byte is
// absorbed in the cycle it is accepted. A byte that completes a frame loads
// the 16-cell channel shift chain, which then presents one channel beat per
// cycle while rsp_stall is low. req_stall rises only when the chain still
// holds channels and the offered byte would complete another frame.
// Reset is synchronous and clears the byte count, tick count and chain
// occupancy, and returns the gap limit to its default of two; window bytes
// are not cleared, as the byte count keeps them from being used until they
// have all been written.
// ----------------------------------------------------------------------------
module sbus_frame_receiver (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [7:0]                            req_rx_byte,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sbfr_pkg::INDEX_BITS-1:0]       rsp_channel_index,
   output logic [sbfr_pkg::CHAN_BITS-1:0]        rsp_channel_value,
   output logic                                  rsp_last_channel,
   // Configuration
   input  logic                                  csr_wr_en,
   input  logic [7:0]                            csr_wr_data
);

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   logic [7:0]                              gap_limit_ff;
   logic [sbfr_pkg::GAP_COUNT_BITS-1:0]     ticks_ff, ticks_in;
   logic [sbfr_pkg::SEEN_BITS-1:0]          seen_ff, seen_in;
   logic                                    busy_ff, busy_in;
   logic [sbfr_pkg::INDEX_BITS-1:0]         index_ff, index_in;

   // ------------------------------------------------------------------------
   // Handshake decode
   // ------------------------------------------------------------------------
   logic req_accept;
   logic byte_accept;
   logic tick_accept;
   logic rsp_accept;
   logic gap_seen;
   logic frame_match;
   logic [sbfr_pkg::SEEN_BITS-1:0] seen_base;

   // The window cells, oldest byte in cell 0.
   logic [7:0] win [sbfr_pkg::FRAME_BYTES];

   // A byte arriving after more than gap_limit ticks restarts the count.
   // Comparison is on the saturated tick count.
   assign gap_seen  = (ticks_ff > gap_limit_ff);
   assign seen_base = gap_seen ? '0 : seen_ff;
   assign seen_in   = (seen_base == sbfr_pkg::SEEN_BITS'(sbfr_pkg::FRAME_BYTES)) ?
                      seen_base : seen_base + 1'b1;

   // The window after this byte would be cells 1..24 followed by the new
   // byte, so the frame check looks at cell 1 and the incoming byte.
   assign frame_match = (req_func == sbfr_pkg::FUNC_BYTE) &&
                        (seen_in == sbfr_pkg::SEEN_BITS'(sbfr_pkg::FRAME_BYTES)) &&
                        (win[1] == sbfr_pkg::START_BYTE) &&
                        (req_rx_byte == sbfr_pkg::END_BYTE);

   // Hold off only a frame-completing byte while the chain is still draining.
   assign req_stall   = busy_ff && frame_match;
   assign req_accept  = req_valid && !req_stall;
   assign byte_accept = req_accept && (req_func == sbfr_pkg::FUNC_BYTE);
   assign tick_accept = req_accept && (req_func == sbfr_pkg::FUNC_TICK);
   assign rsp_accept  = busy_ff && !rsp_stall;

   // ------------------------------------------------------------------------
   // Byte window: a chain of byte cells shifting toward cell 0
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < sbfr_pkg::FRAME_BYTES; i++) begin : g_win
      logic [7:0] d_cell;
      if (i == sbfr_pkg::FRAME_BYTES - 1) begin : g_tail
         assign d_cell = req_rx_byte;
      end else begin : g_body
         assign d_cell = win[i+1];
      end
      sbfr_byte_cell u_cell (
         .clock (clock),
         .shift (byte_accept),
         .d_in  (d_cell),
         .q     (win[i])
      );
   end

   // ------------------------------------------------------------------------
   // Frame snapshot: data bytes 1..22 of the new window are cells 2..23
   // now. Laid out LSB first they form one 176-bit stream cut into channels.
   // ------------------------------------------------------------------------
   logic [sbfr_pkg::DATA_BYTES*8-1:0] stream;

   for (genvar j = 0; j < sbfr_pkg::DATA_BYTES; j++) begin : g_stream
      assign stream[8*j +: 8] = win[j+2];
   end

   // ------------------------------------------------------------------------
   // Channel chain: cell 0 is the channel on the result port; each accepted
   // result beat moves the others one place down.
   // ------------------------------------------------------------------------
   sbfr_pkg::chan_ctl_type chan_ctl;
   logic [sbfr_pkg::CHAN_BITS-1:0] chan_q [sbfr_pkg::CHANNELS];

   assign chan_ctl.load  = byte_accept && frame_match;
   assign chan_ctl.shift = rsp_accept;

   for (genvar k = 0; k < sbfr_pkg::CHANNELS; k++) begin : g_chan
      logic [sbfr_pkg::CHAN_BITS-1:0] next_val;
      if (k == sbfr_pkg::CHANNELS - 1) begin : g_tail
         assign next_val = '0;
      end else begin : g_body
         assign next_val = chan_q[k+1];
      end
      sbfr_chan_cell u_cell (
         .clock    (clock),
         .ctl      (chan_ctl),
         .load_val (stream[sbfr_pkg::CHAN_BITS*k +: sbfr_pkg::CHAN_BITS]),
         .shift_in (next_val),
         .q        (chan_q[k])
      );
   end

   // ------------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------------
   always_comb begin
      ticks_in = ticks_ff;
      if (byte_accept) begin
         ticks_in = '0;
      end else if (tick_accept && (ticks_ff != '1)) begin
         ticks_in = ticks_ff + 1'b1;
      end

      busy_in  = busy_ff;
      index_in = index_ff;
      if (chan_ctl.load) begin
         busy_in  = 1'b1;
         index_in = '0;
      end else if (rsp_accept) begin
         index_in = index_ff + 1'b1;
         if (rsp_last_channel) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= sbfr_pkg::GAP_LIMIT_RESET;
         ticks_ff     <= '0;
         seen_ff      <= '0;
         busy_ff      <= 1'b0;
         index_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            gap_limit_ff <= csr_wr_data;
         end
         if (byte_accept) begin
            seen_ff <= seen_in;
         end
         ticks_ff <= ticks_in;
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result port
   // ------------------------------------------------------------------------
   assign rsp_valid         = busy_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_channel_value = chan_q[0];
   assign rsp_last_channel  = (index_ff == sbfr_pkg::INDEX_BITS'(sbfr_pkg::CHANNELS - 1));

endmodule

// File: design/sbfr_checker.sv
// ----------------------------------------------------------------------------
// S.BUS frame receiver checker
// Port-level assertions on the result sequence and input stalls.
// ----------------------------------------------------------------------------
`include "sbus_frame_receiver_macros.svh"

module sbfr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [sbfr_pkg::INDEX_BITS-1:0]       rsp_channel_index,
   input logic [sbfr_pkg::CHAN_BITS-1:0]        rsp_channel_value,
   input logic                                  rsp_last_channel
);

   // A stalled result beat holds.
   `SBFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_channel_index) && $stable(rsp_channel_value), "stalled result beat changed")

   // Channels of a frame follow one another without a gap.
   `SBFR_ASSERT_NEXT(a_rsp_next, rsp_valid && !rsp_stall && !rsp_last_channel, rsp_valid && (rsp_channel_index == sbfr_pkg::INDEX_BITS'($past(rsp_channel_index) + 1'b1)), "channel sequence broken")

   // Every frame starts at channel zero.
   `SBFR_ASSERT_NOW(a_rsp_first, $rose(rsp_valid), rsp_channel_index == '0, "frame did not start at channel zero")

   // Input is held off only while channels are still waiting.
   `SBFR_ASSERT_NOW(a_req_stall, req_valid && req_stall, rsp_valid, "input stalled with no pending channels")

endmodule

bind sbus_frame_receiver sbfr_checker u_sbfr_checker (.*);
